// ===== src/ddl_source_tokenizer_defines.svh =====
// Assertion helpers used by the top-level tokenizer file.
`ifndef DDL_SOURCE_TOKENIZER_DEFINES_SVH
`define DDL_SOURCE_TOKENIZER_DEFINES_SVH

// Same-cycle implication under the synchronous reset.
`define DDL_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ddl tokenizer check failed");

// Next-cycle implication under the synchronous reset.
`define DDL_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ddl tokenizer check failed");

`endif

// ===== src/ddl_tok_pkg.sv =====
package ddl_tok_pkg;

  // scanner modes
  localparam logic [4:0] M_IDLE  = 5'd0;
  localparam logic [4:0] M_ZERO  = 5'd1;
  localparam logic [4:0] M_HEX   = 5'd2;
  localparam logic [4:0] M_BIN   = 5'd3;
  localparam logic [4:0] M_OCT   = 5'd4;
  localparam logic [4:0] M_DEC   = 5'd5;
  localparam logic [4:0] M_FRAC  = 5'd6;
  localparam logic [4:0] M_EXP0  = 5'd7;
  localparam logic [4:0] M_EXPS  = 5'd8;
  localparam logic [4:0] M_EXPD  = 5'd9;
  localparam logic [4:0] M_IDENT = 5'd10;
  localparam logic [4:0] M_LIT   = 5'd11;
  localparam logic [4:0] M_SLASH = 5'd12;
  localparam logic [4:0] M_LCOM  = 5'd13;
  localparam logic [4:0] M_BCOM  = 5'd14;
  localparam logic [4:0] M_BSTAR = 5'd15;
  localparam logic [4:0] M_PAIR  = 5'd16;
  localparam logic [4:0] M_DWORD = 5'd17;
  localparam logic [4:0] M_DSP1  = 5'd18;
  localparam logic [4:0] M_DNUM  = 5'd19;
  localparam logic [4:0] M_DSP2  = 5'd20;
  localparam logic [4:0] M_DNAME = 5'd21;

  // token kinds
  localparam logic [4:0] TK_EOF    = 5'd0;
  localparam logic [4:0] TK_IDENT  = 5'd1;
  localparam logic [4:0] TK_LIT    = 5'd2;
  localparam logic [4:0] TK_DEC    = 5'd3;
  localparam logic [4:0] TK_HEX    = 5'd4;
  localparam logic [4:0] TK_OCT    = 5'd5;
  localparam logic [4:0] TK_BIN    = 5'd6;
  localparam logic [4:0] TK_REAL   = 5'd7;
  localparam logic [4:0] TK_OROR   = 5'd8;
  localparam logic [4:0] TK_ANDAND = 5'd9;
  localparam logic [4:0] TK_EQEQ   = 5'd10;
  localparam logic [4:0] TK_NE     = 5'd11;
  localparam logic [4:0] TK_LE     = 5'd12;
  localparam logic [4:0] TK_GE     = 5'd13;
  localparam logic [4:0] TK_SHL    = 5'd14;
  localparam logic [4:0] TK_SHR    = 5'd15;
  localparam logic [4:0] TK_SINGLE = 5'd16;

  // error codes
  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_NUMBER    = 3'd1;
  localparam logic [2:0] E_RESERVED  = 3'd2;
  localparam logic [2:0] E_LITERAL   = 3'd3;
  localparam logic [2:0] E_COMMENT   = 3'd4;
  localparam logic [2:0] E_DIRECTIVE = 3'd5;
  localparam logic [2:0] E_CHAR      = 3'd6;

  // input kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [19:0] LINE_MAX       = 20'hFFFFF;
  localparam logic [19:0] LINE_MAX_DIV10 = 20'd104857;
  localparam logic [2:0]  WORD_DONE      = 3'd4;
  localparam logic [2:0]  WORD_BAD       = 3'd5;

  typedef struct packed {
    logic space;
    logic digit;
    logic alpha;
    logic hexd;
    logic octd;
    logic single;
    logic pairc;
  } char_class_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    char_class_t cls;
  } item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [7:0]  char_code;
    logic [19:0] start_offset;
    logic [20:0] lexeme_length;
    logic [19:0] line_number;
    logic [19:0] file_start;
    logic [20:0] file_length;
    logic [2:0]  error_code;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [2:0] count;
  } oq_stat_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t k;
    k.space  = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    k.digit  = (c >= "0" && c <= "9");
    k.alpha  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
    k.hexd   = k.digit || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    k.octd   = (c >= "0" && c <= "7");
    k.single = (c == ",") || (c == "{") || (c == "}") || (c == "[") || (c == "]") ||
               (c == "(") || (c == ")") || (c == ";") || (c == "?") || (c == ":") ||
               (c == ".") || (c == "^") || (c == "+") || (c == "-") || (c == "*") ||
               (c == "%") || (c == "~");
    k.pairc  = (c == "|") || (c == "&") || (c == "=") || (c == "!") || (c == "<") ||
               (c == ">");
    return k;
  endfunction

  function automatic logic [4:0] pair_code(input logic [7:0] p, input logic [7:0] c);
    logic [4:0] k;
    k = TK_EOF;
    if (p == "|" && c == "|") k = TK_OROR;
    else if (p == "&" && c == "&") k = TK_ANDAND;
    else if (p == "=" && c == "=") k = TK_EQEQ;
    else if (p == "!" && c == "=") k = TK_NE;
    else if (p == "<" && c == "=") k = TK_LE;
    else if (p == ">" && c == "=") k = TK_GE;
    else if (p == "<" && c == "<") k = TK_SHL;
    else if (p == ">" && c == ">") k = TK_SHR;
    return k;
  endfunction

  function automatic logic [7:0] word_char(input logic [2:0] pos);
    logic [7:0] w;
    unique case (pos)
      3'd0:    w = "l";
      3'd1:    w = "i";
      3'd2:    w = "n";
      3'd3:    w = "e";
      default: w = 8'd0;
    endcase
    return w;
  endfunction

  function automatic logic [20:0] span(input logic [20:0] a, input logic [20:0] b);
    return (b > a) ? (b - a) : 21'd0;
  endfunction

  function automatic res_t mk_res(input logic [4:0] kind, input logic [7:0] ch,
                                  input logic [19:0] start, input logic [20:0] len,
                                  input logic [19:0] line, input logic [19:0] fs,
                                  input logic [20:0] fl, input logic [2:0] err);
    res_t r;
    r.token_kind    = kind;
    r.char_code     = ch;
    r.start_offset  = start;
    r.lexeme_length = len;
    r.line_number   = line;
    r.file_start    = fs;
    r.file_length   = fl;
    r.error_code    = err;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

endpackage

// ===== src/ddl_source_tokenizer.sv =====
// Streaming tokenizer for a C-like data-definition language.
// Input channel (in_valid/in_ready): one request per source byte, in_kind 0,
// then a request with in_kind 1 to close the buffer. Each request yields zero,
// one or two tokens on the output channel (out_valid/out_ready); the last
// token of a request carries out_last_of_run. Every error is sticky: later
// bytes give nothing until the end request, which silently rearms the scanner.
// Configuration: cfg_we writes cfg_wdata into reject_double_underscore; write
// it only while the block is idle.
// Throughput: one request per cycle while the output side drains; the front
// queue (two entries, with byte classification) and the result queue (four
// entries) let each side stall on its own. The scanner takes a request only
// when the result queue has room for two tokens.
// Path: an accepted request is registered in the front queue; the scanner
// scans it combinationally into the registered result queue, waiting while
// that queue lacks room, and its tokens are offered from there.
// Reset (rst_n low, synchronous): both queues empty, scanner idle at offset
// zero, line one, no file name, register cleared. When out_ready is low,
// results collect in the result queue; the scanner stops once it holds more
// than two, in_ready drops once the front queue fills, and nothing is lost.
module ddl_source_tokenizer import ddl_tok_pkg::*; #(
  parameter longint unsigned MAX_BYTES = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_source_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [7:0]  out_char_code,
  output logic [19:0] out_start_offset,
  output logic [20:0] out_lexeme_length,
  output logic [19:0] out_line_number,
  output logic [19:0] out_file_start,
  output logic [20:0] out_file_length,
  output logic [2:0]  out_error_code,
  output logic        out_last_of_run
);

  `include "ddl_source_tokenizer_defines.svh"

  // saturation point of offsets
  localparam logic [19:0] OFF_MAX = ((MAX_BYTES - 64'd1) < 64'hFFFFF) ?
                                    20'(MAX_BYTES - 64'd1) : 20'hFFFFF;

  logic     reject_du_r;
  logic     item_valid, item_ready, take;
  item_t    item;
  oq_stat_t oq_stat;
  push_t    push;
  res_t     head;

  // hold the configuration bit until rewritten
  always_ff @(posedge clk) begin
    if (!rst_n) reject_du_r <= 1'b0;
    else if (cfg_we) reject_du_r <= cfg_wdata;
  end

  ddl_tok_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_source_byte,
    .item_valid, .item_ready, .item
  );

  ddl_tok_core #(.OFF_MAX(OFF_MAX)) u_core (
    .clk, .rst_n, .reject_du(reject_du_r), .item_valid, .item_ready, .item,
    .oq_stat, .push, .take
  );

  ddl_tok_outq u_outq (
    .clk, .rst_n, .push, .stat(oq_stat), .out_valid, .out_ready, .head
  );

  assign out_token_kind    = head.token_kind;
  assign out_char_code     = head.char_code;
  assign out_start_offset  = head.start_offset;
  assign out_lexeme_length = head.lexeme_length;
  assign out_line_number   = head.line_number;
  assign out_file_start    = head.file_start;
  assign out_file_length   = head.file_length;
  assign out_error_code    = head.error_code;
  assign out_last_of_run   = head.last_of_run;

  `DDL_ASSERT_NOW(a_take_room, clk, rst_n, take, oq_stat.count <= 3'd2)
  `DDL_ASSERT_NOW(a_err_kind, clk, rst_n, out_valid && out_error_code != E_NONE,
                  out_token_kind == TK_EOF)
  `DDL_ASSERT_NOW(a_kind_range, clk, rst_n, out_valid, out_token_kind <= TK_SINGLE)
  `DDL_ASSERT_NEXT(a_queue_fill, clk, rst_n, take && push.cnt == 2'd2,
                   oq_stat.count >= 3'd2)

endmodule

// ===== src/ddl_tok_front.sv =====
module ddl_tok_front import ddl_tok_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_source_byte,
  output logic       item_valid,
  input  logic       item_ready,
  output item_t      item
);

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  item_t      new_item;

  assign in_ready   = (cnt_r != 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_comb begin
    new_item.kind = in_kind;
    new_item.ch   = in_source_byte;
    new_item.cls  = classify(in_source_byte);
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= new_item;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/ddl_tok_core.sv =====
module ddl_tok_core import ddl_tok_pkg::*; #(
  parameter logic [19:0] OFF_MAX = 20'hFFFFF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     reject_du,
  input  logic     item_valid,
  output logic     item_ready,
  input  item_t    item,
  input  oq_stat_t oq_stat,
  output push_t    push,
  output logic     take
);

  logic [4:0]  mode_r;
  logic [19:0] coff_r, tstart_r, cline_r, tline_r, dval_r, nstart_r;
  logic [20:0] nlen_r;
  logic [7:0]  oq_r, pchar_r;
  logic [1:0]  lu_r;
  logic [2:0]  wpos_r;
  logic        halted_r, owed_r;

  logic [4:0]  mode;
  logic [19:0] coff, tstart, cline, tline, dval, nstart;
  logic [20:0] nlen;
  logic [7:0]  oq, pchar;
  logic [1:0]  lu;
  logic [2:0]  wpos;
  logic        halted, owed;
  logic [1:0]  n;
  res_t        r0, r1, pres;
  logic        pv, done, consumed, fin;
  logic [24:0] k;
  logic [4:0]  pk;
  logic [7:0]  c;
  char_class_t cl;

  assign item_ready = (oq_stat.count <= 3'd2);
  assign take       = item_valid && item_ready;

  always_comb begin
    mode = mode_r; coff = coff_r; tstart = tstart_r; cline = cline_r; tline = tline_r;
    dval = dval_r; nstart = nstart_r; nlen = nlen_r; oq = oq_r; pchar = pchar_r;
    lu = lu_r; wpos = wpos_r; halted = halted_r; owed = owed_r;
    n = 2'd0; r0 = '0; r1 = '0; pres = '0; pv = 1'b0; done = 1'b0; consumed = 1'b1;
    fin = 1'b0; k = '0; pk = '0;
    c  = item.ch;
    cl = item.cls;
    if (item.kind == KIND_BYTE) begin
      if (!halted_r) begin
        // up to three passes: a byte that closes a token is seen again from idle
        for (int p = 0; p < 3; p++) begin
          if (!done) begin
            pv = 1'b0;
            consumed = 1'b1;
            unique case (mode)
              M_IDLE: begin
                tstart = coff;
                tline  = cline;
                if (cl.space) begin
                end else if (c == "0") mode = M_ZERO;
                else if (cl.digit) mode = M_DEC;
                else if (cl.alpha) begin
                  mode = M_IDENT;
                  lu   = (c == "_") ? 2'd1 : 2'd0;
                end else if (c == 8'h22 || c == 8'h27) begin
                  mode = M_LIT;
                  oq   = c;
                end else if (cl.single) begin
                  pv = 1'b1;
                  pres = mk_res(TK_SINGLE, c, tstart, 21'd1, tline, nstart, nlen, E_NONE);
                end else if (c == "/") mode = M_SLASH;
                else if (cl.pairc) begin
                  mode  = M_PAIR;
                  pchar = c;
                end else if (c == "#") begin
                  mode = M_DWORD;
                  wpos = 3'd0;
                end else begin
                  pv = 1'b1;
                  pres = mk_res(TK_EOF, c, coff, 21'd1, cline, nstart, nlen, E_CHAR);
                  halted = 1'b1;
                end
              end
              M_ZERO: begin
                if (c == "x") mode = M_HEX;
                else if (c == "b") mode = M_BIN;
                else if (cl.octd) mode = M_OCT;
                else if (cl.digit) mode = M_DEC;
                else if (c == ".") mode = M_FRAC;
                else if (c == "e" || c == "E") mode = M_EXP0;
                else if (c == "f") begin
                  pv = 1'b1; mode = M_IDLE;
                  pres = mk_res(TK_REAL, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}) + 21'd1,
                                tline, nstart, nlen, E_NONE);
                end else begin
                  pv = 1'b1; mode = M_IDLE; consumed = 1'b0;
                  pres = mk_res(TK_DEC, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}),
                                tline, nstart, nlen, E_NONE);
                end
              end
              M_HEX, M_BIN, M_OCT: begin
                if (mode == M_HEX) pk = TK_HEX;
                else if (mode == M_BIN) pk = TK_BIN;
                else pk = TK_OCT;
                if ((mode == M_HEX && cl.hexd) || (mode == M_BIN && (c == "0" || c == "1")) ||
                    (mode == M_OCT && cl.octd)) begin
                end else begin
                  pv = 1'b1; mode = M_IDLE; consumed = 1'b0;
                  pres = mk_res(pk, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}),
                                tline, nstart, nlen, E_NONE);
                end
              end
              M_DEC, M_FRAC: begin
                if (cl.digit) begin
                end else if (c == "." && mode == M_DEC) mode = M_FRAC;
                else if (c == "e" || c == "E") mode = M_EXP0;
                else if (c == "f") begin
                  pv = 1'b1; mode = M_IDLE;
                  pres = mk_res(TK_REAL, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}) + 21'd1,
                                tline, nstart, nlen, E_NONE);
                end else begin
                  pk = (mode == M_DEC) ? TK_DEC : TK_REAL;
                  pv = 1'b1; mode = M_IDLE; consumed = 1'b0;
                  pres = mk_res(pk, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}),
                                tline, nstart, nlen, E_NONE);
                end
              end
              M_EXP0, M_EXPS: begin
                if (mode == M_EXP0 && (c == "+" || c == "-")) mode = M_EXPS;
                else if (cl.digit) mode = M_EXPD;
                else begin
                  pv = 1'b1; mode = M_IDLE; halted = 1'b1;
                  pres = mk_res(TK_EOF, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}),
                                tline, nstart, nlen, E_NUMBER);
                end
              end
              M_EXPD: begin
                if (cl.digit) begin
                end else if (c == "f") begin
                  pv = 1'b1; mode = M_IDLE;
                  pres = mk_res(TK_REAL, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}) + 21'd1,
                                tline, nstart, nlen, E_NONE);
                end else begin
                  pv = 1'b1; mode = M_IDLE; consumed = 1'b0;
                  pres = mk_res(TK_REAL, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}),
                                tline, nstart, nlen, E_NONE);
                end
              end
              M_IDENT: begin
                if (cl.alpha || cl.digit) begin
                  if (c == "_" && lu == 2'd1 && span({1'b0, tstart}, {1'b0, coff}) == 21'd1)
                    lu = 2'd2;
                end else if (reject_du && lu == 2'd2) begin
                  pv = 1'b1; mode = M_IDLE; halted = 1'b1;
                  pres = mk_res(TK_EOF, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}),
                                tline, nstart, nlen, E_RESERVED);
                end else begin
                  pv = 1'b1; mode = M_IDLE; consumed = 1'b0;
                  pres = mk_res(TK_IDENT, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}),
                                tline, nstart, nlen, E_NONE);
                end
              end
              M_LIT: begin
                if (c == oq) begin
                  pv = 1'b1; mode = M_IDLE;
                  pres = mk_res(TK_LIT, 8'd0, (tstart < OFF_MAX) ? tstart + 20'd1 : OFF_MAX,
                                span({1'b0, tstart} + 21'd1, {1'b0, coff}),
                                tline, nstart, nlen, E_NONE);
                end
              end
              M_SLASH: begin
                if (c == "/") mode = M_LCOM;
                else if (c == "*") mode = M_BCOM;
                else begin
                  pv = 1'b1; mode = M_IDLE; consumed = 1'b0;
                  pres = mk_res(TK_SINGLE, "/", tstart, 21'd1, tline, nstart, nlen, E_NONE);
                end
              end
              M_LCOM: begin
                if (c == 8'h0A) begin
                  mode = M_IDLE; consumed = 1'b0;
                end
              end
              M_BCOM: begin
                if (c == "*") mode = M_BSTAR;
              end
              M_BSTAR: begin
                if (c == "/") mode = M_IDLE;
                else if (c != "*") mode = M_BCOM;
              end
              M_PAIR: begin
                pk = pair_code(pchar, c);
                pv = 1'b1; mode = M_IDLE;
                if (pk != TK_EOF) begin
                  pres = mk_res(pk, 8'd0, tstart, 21'd2, tline, nstart, nlen, E_NONE);
                end else begin
                  consumed = 1'b0;
                  pres = mk_res(TK_SINGLE, pchar, tstart, 21'd1, tline, nstart, nlen, E_NONE);
                end
              end
              M_DWORD: begin
                if (cl.space) begin
                  if (wpos == WORD_DONE) mode = M_DSP1;
                  else begin
                    pv = 1'b1; mode = M_IDLE; halted = 1'b1;
                    pres = mk_res(TK_EOF, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}),
                                  tline, nstart, nlen, E_DIRECTIVE);
                  end
                end else if (wpos < WORD_DONE && c == word_char(wpos)) wpos = wpos + 3'd1;
                else wpos = WORD_BAD;
              end
              M_DSP1: begin
                if (!cl.space) begin
                  dval = 20'd0; mode = M_DNUM; consumed = 1'b0;
                end
              end
              M_DNUM: begin
                if (cl.digit) begin
                  k = 25'(dval) * 25'd10 + 25'(c - "0");
                  dval = (dval > LINE_MAX_DIV10 || k > 25'(LINE_MAX)) ? LINE_MAX : k[19:0];
                end else begin
                  // the newline closing the directive brings the counter to the number
                  if (dval == 20'd0) begin
                    cline = 20'd0; owed = 1'b1;
                  end else begin
                    cline = dval - 20'd1; owed = 1'b0;
                  end
                  mode = M_DSP2; consumed = 1'b0;
                end
              end
              M_DSP2: begin
                if (!cl.space) begin
                  dval = (coff < OFF_MAX) ? coff + 20'd1 : OFF_MAX;
                  mode = M_DNAME;
                end
              end
              M_DNAME: begin
                if (c == 8'h22) begin
                  nstart = dval;
                  nlen   = span({1'b0, dval}, {1'b0, coff});
                  mode   = M_IDLE;
                end
              end
              default: begin
                mode = M_IDLE; consumed = 1'b0;
              end
            endcase
            if (pv) begin
              if (n == 2'd0) r0 = pres;
              else r1 = pres;
              n = n + 2'd1;
            end
            if (consumed || halted) done = 1'b1;
          end
        end
        if (!halted) begin
          if (c == 8'h0A) begin
            if (owed) owed = 1'b0;
            else if (cline < LINE_MAX) cline = cline + 20'd1;
          end
          coff = (coff < OFF_MAX) ? coff + 20'd1 : OFF_MAX;
        end
      end
    end else begin
      if (!halted_r) begin
        fin = 1'b1;
        pv  = 1'b1;
        unique case (mode)
          M_ZERO, M_DEC: pres = mk_res(TK_DEC, 8'd0, tstart,
                                       span({1'b0, tstart}, {1'b0, coff}), tline, nstart, nlen,
                                       E_NONE);
          M_HEX: pres = mk_res(TK_HEX, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}), tline,
                               nstart, nlen, E_NONE);
          M_BIN: pres = mk_res(TK_BIN, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}), tline,
                               nstart, nlen, E_NONE);
          M_OCT: pres = mk_res(TK_OCT, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}), tline,
                               nstart, nlen, E_NONE);
          M_FRAC, M_EXPD: pres = mk_res(TK_REAL, 8'd0, tstart,
                                        span({1'b0, tstart}, {1'b0, coff}), tline, nstart, nlen,
                                        E_NONE);
          M_EXP0, M_EXPS: begin
            fin = 1'b0;
            pres = mk_res(TK_EOF, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}), tline,
                          nstart, nlen, E_NUMBER);
          end
          M_IDENT: begin
            if (reject_du && lu == 2'd2) begin
              fin = 1'b0;
              pres = mk_res(TK_EOF, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}), tline,
                            nstart, nlen, E_RESERVED);
            end else begin
              pres = mk_res(TK_IDENT, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}), tline,
                            nstart, nlen, E_NONE);
            end
          end
          M_LIT: begin
            fin = 1'b0;
            pres = mk_res(TK_EOF, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}), tline,
                          nstart, nlen, E_LITERAL);
          end
          M_BCOM, M_BSTAR: begin
            fin = 1'b0;
            pres = mk_res(TK_EOF, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}), tline,
                          nstart, nlen, E_COMMENT);
          end
          M_SLASH: pres = mk_res(TK_SINGLE, "/", tstart, 21'd1, tline, nstart, nlen, E_NONE);
          M_PAIR:  pres = mk_res(TK_SINGLE, pchar, tstart, 21'd1, tline, nstart, nlen, E_NONE);
          M_DWORD, M_DSP1, M_DNUM, M_DSP2, M_DNAME: begin
            fin = 1'b0;
            pres = mk_res(TK_EOF, 8'd0, tstart, span({1'b0, tstart}, {1'b0, coff}), tline,
                          nstart, nlen, E_DIRECTIVE);
          end
          default: pv = 1'b0;
        endcase
        if (pv) begin
          r0 = pres;
          n  = 2'd1;
        end
        if (fin || !pv) begin
          if (n == 2'd0) r0 = mk_res(TK_EOF, 8'd0, coff, 21'd0, cline, nstart, nlen, E_NONE);
          else r1 = mk_res(TK_EOF, 8'd0, coff, 21'd0, cline, nstart, nlen, E_NONE);
          n = n + 2'd1;
        end
      end
    end
    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = 1'b1;
  end

  always_comb begin
    push.cnt = take ? n : 2'd0;
    push.r0  = r0;
    push.r1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && item.kind == KIND_END)) begin
      mode_r <= M_IDLE; coff_r <= 20'd0; tstart_r <= 20'd0;
      cline_r <= 20'd1; tline_r <= 20'd1; oq_r <= 8'd0; lu_r <= 2'd0;
      dval_r <= 20'd0; nstart_r <= 20'd0; nlen_r <= 21'd0; halted_r <= 1'b0;
      pchar_r <= 8'd0; wpos_r <= 3'd0; owed_r <= 1'b0;
    end else if (take) begin
      mode_r <= mode; coff_r <= coff; tstart_r <= tstart; cline_r <= cline;
      tline_r <= tline; oq_r <= oq; lu_r <= lu; dval_r <= dval; nstart_r <= nstart;
      nlen_r <= nlen; halted_r <= halted; pchar_r <= pchar; wpos_r <= wpos; owed_r <= owed;
    end
  end

endmodule

// ===== src/ddl_tok_outq.sv =====
module ddl_tok_outq import ddl_tok_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  push_t    push,
  output oq_stat_t stat,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     head
);

  res_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign out_valid  = (cnt_r != 3'd0);
  assign head       = q_r[rp_r];
  assign pop        = out_valid && out_ready;
  assign stat.count = cnt_r;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wp_r] <= push.r0;
    if (push.cnt == 2'd2) q_r[wp_r + 2'd1] <= push.r1;
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_r + push.cnt;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, push.cnt} - {2'b0, pop};
    end
  end

endmodule
